FILE: rtl/core/sida_pkg.sv
// Shared constants and elaboration helpers for the signed decimal ASCII converter.
package sida_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int RADIX           = 10;
  localparam int MAX_POW         = 20;

  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_MINUS = 7'd45;
  localparam logic [6:0] ASCII_NINE  = 7'd57;

  // decimal digits needed for the largest magnitude, 2^(w-1)
  function automatic int num_digits(input int w);
    longint unsigned lim;
    longint unsigned p;
    int n;
    int i;
    lim = 64'd1 << (w - 1);
    p   = 64'(RADIX);
    n   = 1;
    for (i = 0; i < MAX_POW; i++) begin
      if (p <= lim) begin
        n++;
        p = p * 64'(RADIX);
      end
    end
    return n;
  endfunction

  function automatic longint unsigned pow10(input int e);
    longint unsigned p;
    int i;
    p = 64'd1;
    for (i = 0; i < MAX_POW; i++) begin
      if (i < e) begin
        p = p * 64'(RADIX);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter, pipelined digit extraction and serialiser.
//
// Usage:
//   Input channel in_valid/in_ready/in_value takes one signed integer per beat.
//   Output channel out_valid/out_ready/out_char_code/out_last gives the text,
//   one ASCII character per beat, most significant first: an optional '-',
//   then the digits without leading zeros ("0" for zero). out_last marks the
//   final character of each number.
// Pipeline: stage 0 forms the magnitude, stages 1..NDIG (NDIG = digits of
//   the largest magnitude, 5 at 16 bits) each resolve one decimal digit by
//   constant compares, and the serialiser register presents the characters.
// Throughput: the pipeline takes a number every cycle while it is not stalled;
//   the serialiser emits one character per cycle while out_ready is high. A number
//   yields 1 to NDIG+1 characters (1 to 6 at 16 bits), so the sustained rate is set by the output port.
// Reset: rst_n (synchronous, active low) empties all stages and the serialiser.
// Stall: with out_ready low the current character holds; stages fill up
//   behind it and in_ready drops once stage 0 is full. Nothing is lost.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [6:0]                    out_char_code,
  output logic                          out_last
);

  localparam int MAGW = VALUE_WIDTH + 1;
  localparam int CW   = MAGW + 4;
  localparam int NDIG = num_digits(VALUE_WIDTH);
  localparam int PW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  typedef logic [NDIG-1:0][3:0] digs_t;

  logic              v_r       [0:NDIG];
  logic              neg_r     [0:NDIG];
  logic [MAGW-1:0]   rem_r     [0:NDIG];
  digs_t             dig_r     [0:NDIG];
  logic              started_r [0:NDIG];
  logic [PW-1:0]     fpos_r    [0:NDIG];
  logic              rdy       [0:NDIG+1];

  logic              sv_r;
  logic              sneg_r;
  logic [PW-1:0]     sptr_r;
  digs_t             sdig_r;
  logic              take;
  logic              fire;

  // stage 0: magnitude, one bit wider so the most negative value is exact
  logic [MAGW-1:0]   mag_nxt;

  assign mag_nxt  = in_value[VALUE_WIDTH-1] ? (~{in_value[VALUE_WIDTH-1], in_value} + 1'b1)
                                            : {1'b0, in_value};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      neg_r[0]     <= in_value[VALUE_WIDTH-1];
      rem_r[0]     <= mag_nxt;
      dig_r[0]     <= '0;
      started_r[0] <= 1'b0;
      fpos_r[0]    <= '0;
    end
  end

  genvar s;
  generate
    for (s = 0; s <= NDIG; s++) begin : g_rdy
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end

    for (s = 1; s <= NDIG; s++) begin : g_dig
      localparam int P = NDIG - s;
      logic [MAGW-1:0] rem_nxt;
      digs_t           dig_nxt;
      logic            started_nxt;
      logic [PW-1:0]   fpos_nxt;

      always_comb begin
        logic [3:0]      d;
        logic [CW-1:0]   sub;
        logic [CW-1:0]   lim;
        logic [63:0]     c;
        d   = '0;
        sub = '0;
        for (int k = 1; k < RADIX; k++) begin
          c   = 64'(k) * pow10(P);
          lim = c[CW-1:0];
          if ({4'b0, rem_r[s-1]} >= lim) begin
            d   = 4'(k);
            sub = lim;
          end
        end
        rem_nxt     = rem_r[s-1] - sub[MAGW-1:0];
        dig_nxt     = dig_r[s-1];
        dig_nxt[P]  = d;
        started_nxt = started_r[s-1];
        fpos_nxt    = fpos_r[s-1];
        if (!started_r[s-1] && ((d != 4'd0) || (P == 0))) begin
          started_nxt = 1'b1;
          fpos_nxt    = PW'(P);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && v_r[s-1]) begin
          neg_r[s]     <= neg_r[s-1];
          rem_r[s]     <= rem_nxt;
          dig_r[s]     <= dig_nxt;
          started_r[s] <= started_nxt;
          fpos_r[s]    <= fpos_nxt;
        end
      end
    end
  endgenerate

  // serialiser: sign first, then digits from the first significant one down
  assign out_valid     = sv_r;
  assign out_char_code = sneg_r ? ASCII_MINUS : (ASCII_ZERO + {3'b0, sdig_r[sptr_r]});
  assign out_last      = !sneg_r && (sptr_r == '0);
  assign fire          = out_valid && out_ready;
  assign take          = !sv_r || (fire && out_last);
  assign rdy[NDIG+1]   = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (take) begin
      sv_r <= v_r[NDIG];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sneg_r <= neg_r[NDIG];
      sptr_r <= fpos_r[NDIG];
      sdig_r <= dig_r[NDIG];
    end else if (fire) begin
      if (sneg_r) begin
        sneg_r <= 1'b0;
      end else begin
        sptr_r <= sptr_r - 1'b1;
      end
    end
  end

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == ASCII_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !sneg_r) |-> (out_char_code >= ASCII_ZERO && out_char_code <= ASCII_NINE))
    else $error("digit character out of range");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r[0] && sv_r))
    else $error("input blocked with an empty stage");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NDIG] && !take) |=> (v_r[NDIG] && $stable(fpos_r[NDIG]) && $stable(dig_r[NDIG])))
    else $error("final stage changed while stalled");

endmodule

FILE: sim/signed_int_to_decimal_ascii_test.sv
// Self-checking bench for the signed decimal ASCII converter: corner values, then random bursts.
module signed_int_to_decimal_ascii_test
  import sida_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int NDIG = num_digits(VW);
  localparam int RANDOM_VALUES = 357;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } ascii_beat_t;

  class ascii_scoreboard;
    ascii_beat_t expected_chars[$];
    int mismatches;
    int chars_checked;
    int values_noted;
    int negatives_noted;

    function void note_value(input logic [VW-1:0] value);
      logic [VW:0] mag;
      logic [3:0]  digits[12];
      int          nd;
      int          k;
      ascii_beat_t beat;
      mag = value[VW-1] ? ((VW+1)'(1) << VW) - {1'b0, value} : {1'b0, value};
      nd = 0;
      do begin
        digits[nd] = 4'(mag % RADIX);
        nd++;
        mag = (VW+1)'(mag / RADIX);
      end while (mag != 0);
      if (value[VW-1]) begin
        beat.code = ASCII_MINUS;
        beat.last = 1'b0;
        expected_chars.push_back(beat);
        negatives_noted++;
      end
      for (k = nd - 1; k >= 0; k--) begin
        beat.code = ASCII_ZERO + 7'(digits[k]);
        beat.last = (k == 0);
        expected_chars.push_back(beat);
      end
      values_noted++;
    endfunction

    function void check_char(input logic [6:0] code, input logic last);
      ascii_beat_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat, char_code %0d last %0b", $time, code, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $display("%0t: char_code expected %0d actual %0d", $time, want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [VW-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [6:0]           out_char_code;
  logic                 out_last;

  ascii_scoreboard sb;
  int burst_left = 0;
  int input_stall_cycles = 0;
  bit long_hold_done = 1'b0;
  int corner_values[$] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999, 1000, 9999,
                           10000, -10000, 32767, -32767, -32768, 12345, -12345,
                           21845, -21846, 30000};

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char_code(out_char_code),
    .out_last(out_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_char(out_char_code, out_last);
    end
    if (rst_n && in_valid && !in_ready) begin
      input_stall_cycles++;
    end
  end

  // bursts of beats with random idle gaps between them
  task automatic offer_value(input logic [VW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_value(v);
  endtask

  task automatic random_value(output logic [VW-1:0] v);
    int d;
    int p;
    int lo;
    int hi;
    int m;
    bit neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9)) inside
      [0:3]: begin
        v = VW'($urandom);
        return;
      end
      [4:6]: begin
        d = $urandom_range(1, NDIG);
        p = 1;
        repeat (d - 1) p = p * RADIX;
        lo = (d == 1) ? 0 : p;
        hi = (d == NDIG) ? 32768 : p * RADIX - 1;
        m = $urandom_range(lo, hi);
      end
      7: begin
        m = $urandom_range(0, 20);
      end
      8: begin
        p = 1;
        repeat ($urandom_range(0, NDIG - 1)) p = p * RADIX;
        m = p + $urandom_range(0, 2) - 1;
      end
      default: begin
        m = $urandom_range(0, 1) ? 32767 : 32768;
      end
    endcase
    if (m == 32768) begin
      neg = 1'b1;
    end
    v = VW'(neg ? -m : m);
  endtask

  initial begin : receiver
    int mode;
    int span;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!long_hold_done && sb.values_noted >= 80) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ~out_ready;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [VW-1:0] v;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_values[i]) begin
      offer_value(VW'(corner_values[i]));
    end
    repeat (RANDOM_VALUES) begin
      random_value(v);
      offer_value(v);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * (NDIG + 2)) @(posedge clk);
    sb.mismatches += sb.pending();
    $display("Converted %0d values (%0d negative) into %0d checked characters.",
             sb.values_noted, sb.negatives_noted, sb.chars_checked);
    $display("Input held back for %0d cycles, including one long receiver pause.",
             input_stall_cycles);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sida_pkg.sv
rtl/core/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_test.sv
